// ----- design/msp_pkg.sv -----
`default_nettype none

package msp_pkg;

  // Fixed field widths
  localparam int INDEX_W = 8;
  localparam int LEN_W   = 16;
  localparam int TOTAL_W = 13;

  // Word and period constants
  localparam int WORD_BITS      = 32;
  localparam int BIT_CNT_W      = $clog2(WORD_BITS);
  localparam int DEFAULT_PERIOD = 16;

  // Zero-period search limit per bit
  localparam int GUARD_STEPS = 8;
  localparam int GUARD_W     = $clog2(GUARD_STEPS + 1);

  // Fill length lower limit and reset value
  localparam int TOTAL_MIN   = 32;
  localparam int TOTAL_RESET = 4096;

  // Default sizes
  localparam int RECORDS_DEF   = 128;
  localparam int MAX_WORDS_DEF = 4096;

  // Item operations
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_NEXT  = 1'b1
  } op_t;

  // One pattern record as held in the table
  typedef struct packed {
    logic [LEN_W-1:0] mark;
    logic [LEN_W-1:0] space;
    logic [LEN_W-1:0] rep;
  } rec_t;

endpackage

`default_nettype wire

// ----- design/msp_cmd_if.sv -----
`default_nettype none

// Command channel: record writes and next-word requests
interface msp_cmd_if;
  logic                         valid;
  logic                         ready;
  msp_pkg::op_t                 opcode;
  logic [msp_pkg::INDEX_W-1:0]  record_index;
  logic [msp_pkg::LEN_W-1:0]    mark_length;
  logic [msp_pkg::LEN_W-1:0]    space_length;
  logic [msp_pkg::LEN_W-1:0]    repeat_times;

  modport source (
    output valid, opcode, record_index, mark_length, space_length, repeat_times,
    input  ready
  );
  modport sink (
    input  valid, opcode, record_index, mark_length, space_length, repeat_times,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/msp_word_if.sv -----
`default_nettype none

// Result channel: one generated word per next-word item
interface msp_word_if;
  logic                           valid;
  logic                           ready;
  logic [msp_pkg::WORD_BITS-1:0]  pattern_word;
  logic                           last_word;

  modport source (
    output valid, pattern_word, last_word,
    input  ready
  );
  modport sink (
    input  valid, pattern_word, last_word,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/msp_ram.sv -----
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module msp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/mark_space_pattern_generator.sv -----
`default_nettype none

// Channel   Role    Payload
// cmd       sink    opcode, record_index, mark_length, space_length, repeat_times
// word      source  pattern_word, last_word
// cfg       write   cfg_we / cfg_wdata -> total_words
//
// Record write: completes on acceptance. Next-word item: fetch, load, the 32 bits one
// per bit step and then the output register; the next item is taken once its word is
// in the output register. Period switch steps come between bit steps (one per period
// end, one more per skipped zero-length period); a pointer advance returns to fetch.
// Reset clears control state and the per-record valid bits at once; no pass.
// A finished word waits while the previous one is still untaken, with cmd.ready low.
module mark_space_pattern_generator #(
  parameter int RECORDS   = msp_pkg::RECORDS_DEF,
  parameter int MAX_WORDS = msp_pkg::MAX_WORDS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  msp_cmd_if.sink                          cmd,
  msp_word_if.source                       word,
  input  wire logic                        cfg_we,
  input  wire logic [msp_pkg::TOTAL_W-1:0] cfg_wdata
);

  localparam int PTR_W = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam int CNT_W = $clog2(RECORDS + 1);
  localparam int WP_W  = $clog2(MAX_WORDS);
  localparam int CW    = (WP_W + 1 > msp_pkg::TOTAL_W) ? WP_W + 1 : msp_pkg::TOTAL_W;
  localparam int IXC_W = msp_pkg::INDEX_W + 1;
  localparam int LW    = msp_pkg::LEN_W;
  localparam int WB    = msp_pkg::WORD_BITS;
  localparam int BCW   = msp_pkg::BIT_CNT_W;
  localparam int GW    = msp_pkg::GUARD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_LOAD,
    S_BITS,
    S_DONE
  } state_t;

  state_t                   state;
  logic [PTR_W-1:0]         ptr;
  logic [CNT_W-1:0]         rec_count;
  logic                     level;
  logic [LW-1:0]            period_left;
  logic [LW-1:0]            repeats;
  logic [WB-1:0]            shift_word;
  logic [BCW-1:0]           bit_cnt;
  logic [GW-1:0]            guard;
  logic [WP_W-1:0]          word_pos;
  logic [msp_pkg::TOTAL_W-1:0] total_words;
  logic                     load_period;
  msp_pkg::rec_t            cur;
  logic [RECORDS-1:0]       valid_bits;
  logic                     rd_valid;

  // Command decode
  logic            cmd_acc;
  logic            wr_in_range;
  logic            ram_we;
  msp_pkg::rec_t   wr_rec;
  msp_pkg::rec_t   rd_rec;
  msp_pkg::rec_t   rec_eff;

  assign cmd.ready   = (state == S_IDLE);
  assign cmd_acc     = cmd.valid && cmd.ready;
  assign wr_in_range = IXC_W'(cmd.record_index) < IXC_W'(RECORDS);
  assign ram_we      = cmd_acc && (cmd.opcode == msp_pkg::OP_WRITE) && wr_in_range;

  // Zero mark and zero space is stored as the default space
  always_comb begin
    wr_rec.mark  = cmd.mark_length;
    wr_rec.rep   = cmd.repeat_times;
    wr_rec.space = ((cmd.mark_length == '0) && (cmd.space_length == '0)) ?
                   LW'(msp_pkg::DEFAULT_PERIOD) : cmd.space_length;
  end

  msp_ram #(
    .WIDTH ($bits(msp_pkg::rec_t)),
    .DEPTH (RECORDS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd.record_index[PTR_W-1:0]),
    .wdata (wr_rec),
    .raddr (ptr),
    .rdata (rd_rec)
  );

  // Record as seen by the generator: default when none defined,
  // a never-written slot reads as zero mark and default space
  always_comb begin
    if (rec_count == '0) begin
      rec_eff.mark  = LW'(msp_pkg::DEFAULT_PERIOD);
      rec_eff.space = LW'(msp_pkg::DEFAULT_PERIOD);
      rec_eff.rep   = '0;
    end else if (!rd_valid) begin
      rec_eff.mark  = '0;
      rec_eff.space = LW'(msp_pkg::DEFAULT_PERIOD);
      rec_eff.rep   = '0;
    end else begin
      rec_eff = rd_rec;
    end
  end

  // Period switch helpers
  logic          lvl_n;
  logic [LW-1:0] rep_inc;
  logic          rep_wrap;
  logic          can_adv;
  logic          last_flag;

  assign lvl_n     = ~level;
  assign rep_inc   = repeats + LW'(1);
  assign rep_wrap  = rep_inc >= cur.rep;
  assign can_adv   = (CNT_W'(ptr) + CNT_W'(1)) < rec_count;
  assign last_flag = (CW'(word_pos) + CW'(1)) >= CW'(total_words);

  // Valid bits sampled alongside the RAM read
  always_ff @(posedge clk) begin
    rd_valid <= valid_bits[ptr];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      total_words <= msp_pkg::TOTAL_W'(msp_pkg::TOTAL_RESET);
    end else if (cfg_we && (cfg_wdata >= msp_pkg::TOTAL_W'(msp_pkg::TOTAL_MIN)) &&
                 (CW'(cfg_wdata) <= CW'(MAX_WORDS))) begin
      total_words <= cfg_wdata;
    end
  end

  // Sequencer, bit generator and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ptr         <= '0;
      rec_count   <= '0;
      level       <= 1'b1;
      period_left <= '0;
      repeats     <= '0;
      bit_cnt     <= '0;
      guard       <= '0;
      word_pos    <= '0;
      load_period <= 1'b0;
      valid_bits  <= '0;
      word.valid  <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (word.valid && word.ready && (state != S_DONE)) begin
        word.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            if (cmd.opcode == msp_pkg::OP_WRITE) begin
              if (wr_in_range) begin
                rec_count <= CNT_W'(cmd.record_index) + CNT_W'(1);
                valid_bits[cmd.record_index[PTR_W-1:0]] <= 1'b1;
              end else begin
                rec_count <= '0;
              end
            end else begin
              // Fill start reloads from record 0
              if (word_pos == '0) begin
                ptr         <= '0;
                level       <= 1'b1;
                repeats     <= '0;
                load_period <= 1'b1;
              end else begin
                load_period <= 1'b0;
              end
              bit_cnt <= '0;
              guard   <= '0;
              state   <= S_FETCH;
            end
          end
        end

        // RAM read of the record at ptr in flight
        S_FETCH: begin
          state <= S_LOAD;
        end

        S_LOAD: begin
          cur <= rec_eff;
          if (load_period) begin
            period_left <= level ? rec_eff.mark : rec_eff.space;
          end
          state <= S_BITS;
        end

        S_BITS: begin
          if ((period_left == '0) && (guard != GW'(msp_pkg::GUARD_STEPS))) begin
            // One period switch step
            level <= lvl_n;
            guard <= guard + GW'(1);
            if (lvl_n && (cur.rep != '0)) begin
              if (rep_wrap) begin
                repeats <= '0;
                if (can_adv) begin
                  ptr         <= ptr + PTR_W'(1);
                  load_period <= 1'b1;
                  state       <= S_FETCH;
                end else begin
                  period_left <= cur.mark;
                end
              end else begin
                repeats     <= rep_inc;
                period_left <= cur.mark;
              end
            end else begin
              period_left <= lvl_n ? cur.mark : cur.space;
            end
          end else begin
            // Emit one bit; a period still zero after the search counts as one
            shift_word  <= {shift_word[WB-2:0], level};
            period_left <= (period_left == '0) ? '0 : period_left - LW'(1);
            guard       <= '0;
            bit_cnt     <= bit_cnt + BCW'(1);
            if (bit_cnt == BCW'(WB - 1)) begin
              state <= S_DONE;
            end
          end
        end

        S_DONE: begin
          if (!word.valid || word.ready) begin
            word.valid        <= 1'b1;
            word.pattern_word <= shift_word;
            word.last_word    <= last_flag;
            word_pos          <= last_flag ? '0 : word_pos + WP_W'(1);
            state             <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_REC          = msp_pkg::RECORDS_DEF;
  localparam int WORDS_CAP      = msp_pkg::MAX_WORDS_DEF;
  localparam int INDEX_W        = msp_pkg::INDEX_W;
  localparam int LEN_W          = msp_pkg::LEN_W;
  localparam int TOTAL_W        = msp_pkg::TOTAL_W;
  localparam int WORD_BITS      = msp_pkg::WORD_BITS;
  localparam int DEFAULT_PERIOD = msp_pkg::DEFAULT_PERIOD;
  localparam int GUARD_STEPS    = msp_pkg::GUARD_STEPS;
  localparam int TOTAL_MIN      = msp_pkg::TOTAL_MIN;
  localparam int TOTAL_RESET    = msp_pkg::TOTAL_RESET;
  localparam int SETTLE         = 40;
  localparam int CYCLE_LIMIT    = 3_000_000;

  // One command item as offered on the cmd channel
  typedef struct {
    msp_pkg::op_t       op;
    logic [INDEX_W-1:0] index;
    logic [LEN_W-1:0]   mark;
    logic [LEN_W-1:0]   space;
    logic [LEN_W-1:0]   rep;
  } cmd_item_t;

  // One generated word
  typedef struct packed {
    logic [WORD_BITS-1:0] pattern;
    logic                 last;
  } word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we;
  logic [TOTAL_W-1:0]  cfg_wdata;

  msp_cmd_if  cmd_ch ();
  msp_word_if word_ch ();

  mark_space_pattern_generator u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .word      (word_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the generator state
  msp_pkg::rec_t   rec_tab [N_REC] = '{default: '0};
  int unsigned     rec_count = 0;
  int unsigned     gen_ptr   = 0;
  logic            gen_level = 1'b1;
  int unsigned     gen_left  = 0;
  logic [LEN_W-1:0] gen_reps = '0;
  logic [31:0]     gen_shift = '0;
  int unsigned     fill_pos  = 0;
  int unsigned     fill_len  = TOTAL_RESET;

  word_t pending_words [$];

  int errors       = 0;
  int words_seen   = 0;
  int fills_closed = 0;
  int writes_sent  = 0;
  int burst_left   = 0;
  int hold_req     = 0;
  int hold_len     = 0;
  longint cycles   = 0;

  // Record lookup with the default pattern and the empty-period fix-up
  function automatic void lookup_record(input int unsigned ix, output int unsigned m,
                                        output int unsigned s, output int unsigned r);
    if (rec_count == 0 || ix >= N_REC) begin
      m = DEFAULT_PERIOD;
      s = DEFAULT_PERIOD;
      r = 0;
    end else begin
      m = rec_tab[ix].mark;
      s = rec_tab[ix].space;
      r = rec_tab[ix].rep;
      if (m == 0 && s == 0) s = DEFAULT_PERIOD;
    end
  endfunction

  function automatic int unsigned period_len(input int unsigned ix, input logic lvl);
    int unsigned m, s, r;
    lookup_record(ix, m, s, r);
    return lvl ? m : s;
  endfunction

  // Next 32 bits of the pattern, earliest bit first
  function automatic word_t predict_word();
    word_t w;
    int unsigned m, s, r;
    if (fill_pos == 0) begin
      gen_ptr   = 0;
      gen_level = 1'b1;
      gen_reps  = '0;
      gen_shift = '0;
      gen_left  = period_len(0, 1'b1);
    end
    for (int b = 0; b < WORD_BITS; b++) begin
      if (gen_left == 0) begin
        // skip empty periods, advancing records at each new mark
        for (int g = 0; g < GUARD_STEPS && gen_left == 0; g++) begin
          gen_level = ~gen_level;
          if (gen_level) begin
            lookup_record(gen_ptr, m, s, r);
            if (r != 0) begin
              gen_reps = gen_reps + 1'b1;
              if (gen_reps >= r) begin
                gen_reps = '0;
                if (gen_ptr + 1 < rec_count) gen_ptr++;
              end
            end
          end
          gen_left = period_len(gen_ptr, gen_level);
        end
        if (gen_left == 0) gen_left = 1;
      end
      gen_shift = {gen_shift[30:0], gen_level};
      gen_left--;
    end
    w.pattern = gen_shift;
    w.last    = (fill_pos + 1 >= fill_len);
    fill_pos  = w.last ? 0 : fill_pos + 1;
    return w;
  endfunction

  // Offer one item in bursts with random gaps; update the shadow on acceptance
  task automatic send_item(input cmd_item_t it);
    if (burst_left <= 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 16);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.opcode       <= it.op;
    cmd_ch.record_index <= it.index;
    cmd_ch.mark_length  <= it.mark;
    cmd_ch.space_length <= it.space;
    cmd_ch.repeat_times <= it.rep;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    burst_left--;
    if (it.op == msp_pkg::OP_WRITE) begin
      writes_sent++;
      if (it.index < N_REC) begin
        rec_tab[it.index].mark  = it.mark;
        rec_tab[it.index].rep   = it.rep;
        rec_tab[it.index].space = (it.mark == 0 && it.space == 0) ?
                                  LEN_W'(DEFAULT_PERIOD) : it.space;
        rec_count = it.index + 1;
      end else begin
        rec_count = 0;
      end
    end else begin
      pending_words.push_back(predict_word());
    end
  endtask

  task automatic send_record(input int unsigned ix, input int unsigned m,
                             input int unsigned s, input int unsigned r);
    cmd_item_t it;
    it.op    = msp_pkg::OP_WRITE;
    it.index = INDEX_W'(ix);
    it.mark  = LEN_W'(m);
    it.space = LEN_W'(s);
    it.rep   = LEN_W'(r);
    send_item(it);
  endtask

  // Next-word request; the write fields carry noise
  task automatic send_next(input int n);
    cmd_item_t it;
    repeat (n) begin
      it.op    = msp_pkg::OP_NEXT;
      it.index = INDEX_W'($urandom);
      it.mark  = LEN_W'($urandom);
      it.space = LEN_W'($urandom);
      it.rep   = LEN_W'($urandom);
      send_item(it);
    end
  endtask

  // Random record, short periods mostly so records advance within a few words
  task automatic send_random_record(input int unsigned ix);
    int unsigned m, s, r;
    m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 24);
    s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 24);
    r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4);
    if ($urandom_range(0, 15) == 0) begin
      m = 0;
      s = 0;
    end
    send_record(ix, m, s, r);
  endtask

  // Stop offering and wait for every word still owed
  task automatic drain_words();
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_fill_len(input int unsigned v);
    cfg_we    <= 1'b1;
    cfg_wdata <= TOTAL_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (v >= TOTAL_MIN && v <= WORDS_CAP) fill_len = v;
    @(posedge clk);
  endtask

  // Mostly whole programmes followed by word requests, some noise writes
  task automatic random_traffic(input int n_items);
    int sent;
    int k;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++) begin
          send_random_record(i);
          // occasionally break the programme with a stray index
          if ($urandom_range(0, 19) == 0) begin
            send_random_record($urandom_range(0, 255));
            sent++;
          end
        end
        sent += k;
        k = $urandom_range(4, 40);
        send_next(k);
        sent += k;
      end else if (pick < 17) begin
        send_record($urandom_range(0, 255), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
        sent++;
      end else begin
        k = $urandom_range(1, 30);
        send_next(k);
        sent += k;
      end
    end
  endtask

  task automatic test_default_pattern();
    send_next(3);
  endtask

  task automatic test_record_extremes();
    send_record(0, 1, 1, 0);
    send_next(1);
    send_record(0, 0, 0, 0);
    send_next(1);
    send_record(0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_next(1);
    send_record(255, 4, 4, 1);
    send_next(1);
    send_record(N_REC, 7, 3, 2);
    send_next(1);
    // slot 1 left unwritten between two defined slots
    send_record(0, 0, 5, 2);
    send_record(2, 3, 1, 1);
    send_next(3);
    send_record(N_REC - 1, 2, 2, 1);
    send_next(2);
    send_record(0, 5, 0, 3);
    send_next(1);
  endtask

  // Out-of-range lengths ignored, then the shortest fill
  task automatic test_short_fills();
    drain_words();
    write_fill_len(0);
    write_fill_len(TOTAL_MIN - 1);
    write_fill_len(WORDS_CAP + 1);
    write_fill_len(8191);
    write_fill_len(TOTAL_MIN);
    random_traffic(450);
  endtask

  // Fill length cut below the current position ends the fill at once
  task automatic test_fill_shrink();
    drain_words();
    write_fill_len(200);
    while (fill_pos < 40) send_next(1);
    drain_words();
    write_fill_len(TOTAL_MIN);
    send_next(3);
  endtask

  // Receiver holds off long enough for the block to stall its input
  task automatic test_output_backpressure();
    drain_words();
    hold_len = 800;
    hold_req++;
    burst_left = 1000;
    send_next(40);
    drain_words();
  endtask

  task automatic test_full_fills();
    drain_words();
    write_fill_len(WORDS_CAP);
    random_traffic(300);
  endtask

  task automatic test_odd_fills();
    repeat (3) begin
      drain_words();
      write_fill_len($urandom_range(TOTAL_MIN + 1, 120));
      random_traffic(120);
    end
  endtask

  // Receiver: stall pattern changing every so often, plus requested hold-offs
  int hold_seen = 0;
  int hold_left = 0;
  int mode_left = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst) begin
      word_ch.ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen     <= hold_req;
      hold_left     <= hold_len;
      word_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      word_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: word_ch.ready <= 1'b1;
        1: word_ch.ready <= 1'($urandom_range(0, 1));
        2: word_ch.ready <= (cycles % 7) < 4;
        default: word_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    word_t exp_w;
    if (!rst && word_ch.valid && word_ch.ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word %h (last_word %b)", word_ch.pattern_word, word_ch.last_word);
        errors++;
      end else begin
        exp_w = pending_words.pop_front();
        words_seen++;
        if (word_ch.last_word) fills_closed++;
        if (word_ch.pattern_word !== exp_w.pattern) begin
          $error("pattern_word: expected %h, got %h", exp_w.pattern, word_ch.pattern_word);
          errors++;
        end
        if (word_ch.last_word !== exp_w.last) begin
          $error("last_word: expected %b, got %b", exp_w.last, word_ch.last_word);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    cmd_ch.valid        <= 1'b0;
    cmd_ch.opcode       <= msp_pkg::OP_WRITE;
    cmd_ch.record_index <= '0;
    cmd_ch.mark_length  <= '0;
    cmd_ch.space_length <= '0;
    cmd_ch.repeat_times <= '0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_pattern();
    test_record_extremes();
    test_short_fills();
    test_fill_shrink();
    test_output_backpressure();
    test_full_fills();
    test_odd_fills();
    drain_words();

    $display("Checked %0d words, %0d fills closed, %0d record writes.",
             words_seen, fills_closed, writes_sent);
    $display("Fill lengths 32 to 4096, rejected lengths, a shrunk fill and a long output stall.");
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
